// ===== src/kbte_pkg.sv =====
// ----------------------------------------------------------------------------
// kbte_pkg
// Shared types and constants of the keyframe bounce timeline evaluator.
// ----------------------------------------------------------------------------
package kbte_pkg;

    localparam int DATA_W    = 32;
    localparam int TYPE_W    = 4;
    localparam int CNT_W     = 16;
    localparam int STAT_W    = 2;
    localparam int S_TDATA_W = 216;
    localparam int M_TDATA_W = 40;

    // Shift-subtract divider datapath width and step counter width.
    localparam int DIV_W  = 64;
    localparam int STEP_W = 6;

    localparam logic [STEP_W-1:0] DIV_T_STEPS = 6'd32;
    localparam logic [STEP_W-1:0] DIV_C_STEPS = 6'd32;
    localparam logic [STEP_W-1:0] DIV_Q_STEPS = 6'd33;

    localparam logic OP_BEGIN   = 1'b0;
    localparam logic OP_SEGMENT = 1'b1;

    localparam logic [TYPE_W-1:0] SEG_JUMP = 4'd7;
    localparam logic [TYPE_W-1:0] SEG_HOLD = 4'd8;

    localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_BAD_TYPE   = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_ZERO_CYCLE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_T,
        S_DIV_C,
        S_MUL_K,
        S_MUL_CC,
        S_MUL_LO,
        S_MUL_HI,
        S_LOAD,
        S_DIV_Q
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  rem_init;
        logic [DIV_W-1:0]  num_init;
        logic [DIV_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } t_div_cmd;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] quo;
    } t_div_rsp;

endpackage

// ===== src/keyframe_bounce_timeline_evaluator.sv =====
// ----------------------------------------------------------------------------
// keyframe_bounce_timeline_evaluator
// Evaluates a keyframe timeline of jump and hold segments at one query time.
// ----------------------------------------------------------------------------
// Usage: a begin item (tuser = 0) carries the query time, the repeat offset,
// the start time and the start value. Segment items (tuser = 1) follow, one
// per item. The item with tlast set produces one result item on the master
// side: the timeline value and a status (ok, unsupported type, zero cycle).
// A result caused by a begin, hold or non-matching item is presented on the
// cycle after acceptance. For a matching jump segment the shared 64-bit
// shift-subtract divider runs three times (cycle length 32 steps, phase 32
// steps, bounce quotient 33 steps) and a shared 33x32 multiplier runs four
// times in between.
// The block takes one item at a time; s_tready is low while a jump is being
// worked out and while an unread result is stalled by the receiver.
// The output register holds a result until m_tready takes it.
// Reset clears the query state to zero and drops any pending result.
// ----------------------------------------------------------------------------
module keyframe_bounce_timeline_evaluator
    import kbte_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // query_base[31:0], query_offset[63:32], tl_start[95:64], start_value[127:96],
    // seg_type[131:128], seg_end_time[163:132], seg_end_value[195:164],
    // seg_count[211:196], zero fill above
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // op
    input  logic                 i_s_tuser,
    input  logic                 i_s_tlast,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // value[31:0], status[33:32], zero fill above
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    // Input fields.
    logic [DATA_W-1:0] w_query_base;
    logic [DATA_W-1:0] w_query_ofs;
    logic [DATA_W-1:0] w_tl_start;
    logic [DATA_W-1:0] w_start_value;
    logic [TYPE_W-1:0] w_seg_type;
    logic [DATA_W-1:0] w_seg_end_time;
    logic [DATA_W-1:0] w_seg_end_value;
    logic [CNT_W-1:0]  w_seg_count;

    assign w_query_base    = i_s_tdata[31:0];
    assign w_query_ofs     = i_s_tdata[63:32];
    assign w_tl_start      = i_s_tdata[95:64];
    assign w_start_value   = i_s_tdata[127:96];
    assign w_seg_type      = i_s_tdata[131:128];
    assign w_seg_end_time  = i_s_tdata[163:132];
    assign w_seg_end_value = i_s_tdata[195:164];
    assign w_seg_count     = i_s_tdata[211:196];

    t_state            r_state,     n_state;
    logic [DATA_W-1:0] r_query,     n_query;
    logic [DATA_W-1:0] r_seg_start, n_seg_start;
    logic [DATA_W-1:0] r_run,       n_run;
    logic              r_resolved,  n_resolved;
    logic [DATA_W-1:0] r_res_val,   n_res_val;
    logic [STAT_W-1:0] r_err,       n_err;
    logic              r_last,      n_last;
    logic [DATA_W-1:0] r_t,         n_t;
    logic [DATA_W-1:0] r_c,         n_c;
    logic [63:0]       r_k,         n_k;
    logic [63:0]       r_m,         n_m;
    logic [64:0]       r_plo,       n_plo;
    logic [64:0]       r_phi,       n_phi;
    logic [DATA_W:0]   r_mag,       n_mag;
    logic              r_neg,       n_neg;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_value, n_out_value;
    logic [STAT_W-1:0] r_out_status, n_out_status;

    t_div_cmd w_div_cmd;
    t_div_rsp w_div_rsp;

    logic              w_accept;
    logic              w_emit;
    logic [DATA_W-1:0] w_query_new;
    logic              w_inside;
    logic [DATA_W:0]   w_diff;
    logic [DATA_W-1:0] w_dur;
    logic [DATA_W-1:0] w_offset;
    logic [96:0]       w_num;
    logic [33:0]       w_sum;
    logic [33:0]       w_fixed;
    logic              w_rem_nz;
    logic [DATA_W:0]   w_mul_a;
    logic [DATA_W-1:0] w_mul_b;
    logic [64:0]       w_prod;

    kbte_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_div_cmd),
        .o_rsp   (w_div_rsp)
    );

    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_query_new = w_query_base + w_query_ofs;
    assign w_inside    = ($signed(r_query) > $signed(r_seg_start))
                      && ($signed(r_query) <= $signed(w_seg_end_time));
    assign w_diff      = {w_seg_end_value[DATA_W-1], w_seg_end_value}
                       - {r_run[DATA_W-1], r_run};
    // Inside a segment both spans are positive and below 2^32.
    assign w_dur       = w_seg_end_time - r_seg_start;
    assign w_offset    = r_query - r_seg_start;
    assign w_num       = {r_phi, 32'd0} + {32'd0, r_plo};

    // Running value moved toward the end value by the bounce quotient.
    assign w_sum    = r_neg ? ({{2{r_run[DATA_W-1]}}, r_run} - {1'b0, w_div_rsp.quo[32:0]})
                            : ({{2{r_run[DATA_W-1]}}, r_run} + {1'b0, w_div_rsp.quo[32:0]});
    assign w_rem_nz = |w_div_rsp.rem;

    // A value that crossed zero with an inexact quotient is truncated toward zero.
    always_comb begin
        w_fixed = w_sum;
        if (w_rem_nz && !r_neg && (r_mag != '0) && w_sum[33]) begin
            w_fixed = w_sum + 34'd1;
        end else if (w_rem_nz && r_neg && !w_sum[33] && (w_sum != '0)) begin
            w_fixed = w_sum - 34'd1;
        end
    end

    // Shared multiplier; each product is registered before use.
    always_comb begin
        unique case (r_state)
            S_MUL_K: begin
                w_mul_a = {1'b0, r_t};
                w_mul_b = r_t;
            end
            S_MUL_CC: begin
                w_mul_a = {1'b0, r_c};
                w_mul_b = r_t - r_c;
            end
            S_MUL_LO: begin
                w_mul_a = r_mag;
                w_mul_b = r_m[31:0];
            end
            S_MUL_HI: begin
                w_mul_a = r_mag;
                w_mul_b = r_m[63:32];
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * {1'b0, w_mul_b};

    always_comb begin
        n_state      = r_state;
        n_query      = r_query;
        n_seg_start  = r_seg_start;
        n_run        = r_run;
        n_resolved   = r_resolved;
        n_res_val    = r_res_val;
        n_err        = r_err;
        n_last       = r_last;
        n_t          = r_t;
        n_c          = r_c;
        n_k          = r_k;
        n_m          = r_m;
        n_plo        = r_plo;
        n_phi        = r_phi;
        n_mag        = r_mag;
        n_neg        = r_neg;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        w_emit       = 1'b0;
        w_div_cmd    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_emit = i_s_tlast;
                    if (i_s_tuser == OP_BEGIN) begin
                        n_query     = w_query_new;
                        n_seg_start = w_tl_start;
                        n_run       = w_start_value;
                        n_err       = STATUS_OK;
                        n_resolved  = $signed(w_tl_start) > $signed(w_query_new);
                        n_res_val   = w_start_value;
                    end else if (!r_resolved && (r_err == STATUS_OK)) begin
                        if (w_seg_type == SEG_JUMP) begin
                            if (!w_inside) begin
                                n_run       = w_seg_end_value;
                                n_seg_start = w_seg_end_time;
                            end else if (w_seg_count == '0) begin
                                n_err = STATUS_ZERO_CYCLE;
                            end else begin
                                w_emit             = 1'b0;
                                n_last             = i_s_tlast;
                                n_neg              = w_diff[DATA_W];
                                n_mag              = w_diff[DATA_W] ? (~w_diff + 1'b1) : w_diff;
                                w_div_cmd.start    = 1'b1;
                                w_div_cmd.rem_init = '0;
                                w_div_cmd.num_init = {w_dur, 32'd0};
                                w_div_cmd.divisor  = {48'd0, w_seg_count};
                                w_div_cmd.steps    = DIV_T_STEPS;
                                n_state            = S_DIV_T;
                            end
                        end else if (w_seg_type == SEG_HOLD) begin
                            if (w_inside) begin
                                n_resolved = 1'b1;
                                n_res_val  = r_run;
                            end else begin
                                n_run       = w_seg_end_value;
                                n_seg_start = w_seg_end_time;
                            end
                        end else begin
                            n_err = STATUS_BAD_TYPE;
                        end
                    end
                end
            end
            S_DIV_T: begin
                if (w_div_rsp.done) begin
                    if (w_div_rsp.quo[31:0] == '0) begin
                        n_err   = STATUS_ZERO_CYCLE;
                        w_emit  = r_last;
                        n_state = S_IDLE;
                    end else begin
                        n_t                = w_div_rsp.quo[31:0];
                        w_div_cmd.start    = 1'b1;
                        w_div_cmd.rem_init = '0;
                        w_div_cmd.num_init = {w_offset, 32'd0};
                        w_div_cmd.divisor  = {32'd0, w_div_rsp.quo[31:0]};
                        w_div_cmd.steps    = DIV_C_STEPS;
                        n_state            = S_DIV_C;
                    end
                end
            end
            S_DIV_C: begin
                if (w_div_rsp.done) begin
                    n_c     = w_div_rsp.rem[31:0];
                    n_state = S_MUL_K;
                end
            end
            S_MUL_K: begin
                n_k     = w_prod[63:0];
                n_state = S_MUL_CC;
            end
            S_MUL_CC: begin
                // c*(T-c) is at most T^2/4, so the scaled product fits 64 bits.
                n_m     = {w_prod[61:0], 2'b00};
                n_state = S_MUL_LO;
            end
            S_MUL_LO: begin
                n_plo   = w_prod;
                n_state = S_MUL_HI;
            end
            S_MUL_HI: begin
                n_phi   = w_prod;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                // The quotient fits 33 bits, so the top numerator bits are already
                // a partial remainder below the divisor.
                w_div_cmd.start    = 1'b1;
                w_div_cmd.rem_init = {1'b0, w_num[95:33]};
                w_div_cmd.num_init = {w_num[32:0], 31'd0};
                w_div_cmd.divisor  = r_k;
                w_div_cmd.steps    = DIV_Q_STEPS;
                n_state            = S_DIV_Q;
            end
            S_DIV_Q: begin
                if (w_div_rsp.done) begin
                    n_resolved = 1'b1;
                    n_res_val  = w_fixed[DATA_W-1:0];
                    w_emit     = r_last;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_emit) begin
            n_out_valid  = 1'b1;
            n_out_status = n_err;
            if (n_err != STATUS_OK) begin
                n_out_value = '0;
            end else begin
                n_out_value = n_resolved ? n_res_val : n_run;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_query     <= '0;
            r_seg_start <= '0;
            r_run       <= '0;
            r_resolved  <= 1'b0;
            r_res_val   <= '0;
            r_err       <= STATUS_OK;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_query     <= n_query;
            r_seg_start <= n_seg_start;
            r_run       <= n_run;
            r_resolved  <= n_resolved;
            r_res_val   <= n_res_val;
            r_err       <= n_err;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t          <= n_t;
        r_c          <= n_c;
        r_k          <= n_k;
        r_m          <= n_m;
        r_plo        <= n_plo;
        r_phi        <= n_phi;
        r_mag        <= n_mag;
        r_neg        <= n_neg;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_status, r_out_value};

    // A flagged result never carries a value.
    a_err_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status != STATUS_OK) |-> r_out_value == '0)
        else $error("flagged result with nonzero value");

    // A query is never both resolved and in error.
    a_resolved_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_resolved && (r_err != STATUS_OK)))
        else $error("query resolved and flagged at once");

    // Divider completions only arrive while the sequencer waits for one.
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV_T) || (r_state == S_DIV_C)
                           || (r_state == S_DIV_Q))
        else $error("divider completion outside a divide state");

    // The bounce offset never exceeds the full step toward the end value.
    a_quotient_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done && (r_state == S_DIV_Q) |-> w_div_rsp.quo[32:0] <= r_mag)
        else $error("bounce quotient larger than value step");

    // A new item is never taken while a jump is in progress, and a result
    // only leaves a divide state when the divider has finished.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !w_accept && (w_div_rsp.done || !w_emit))
        else $error("item accepted during jump evaluation");

endmodule

// ===== src/kbte_div.sv =====
// ----------------------------------------------------------------------------
// kbte_div
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kbte_div
    import kbte_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_cmd i_cmd,
    output t_div_rsp o_rsp
);

    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_num;
    logic [DIV_W-1:0]  r_divisor;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIV_W:0]    w_shift;
    logic [DIV_W+1:0]  w_diff;
    logic              w_ge;

    // The partial remainder stays below the divisor, so one extra bit holds the shift.
    assign w_shift = {r_rem, r_num[DIV_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_divisor};
    assign w_ge    = ~w_diff[DIV_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_cmd.steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem     <= i_cmd.rem_init;
            r_num     <= i_cmd.num_init;
            r_divisor <= i_cmd.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_shift[DIV_W-1:0];
            r_num <= {r_num[DIV_W-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;
    assign o_rsp.quo  = r_num;

endmodule
